// ----- rtl/core/rsab_pkg.sv -----
// shared types and constants for the rotated sprite blitter
// used by the front, queue, back and top modules under rtl/core; no dependencies
package rsab_pkg;

  localparam int SPRITE_WORDS = 4096;
  localparam int SPR_AW       = $clog2(SPRITE_WORDS);
  localparam int SCREEN_W     = 1024;
  localparam int SCREEN_H     = 1024;

  // front to back queue
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // result buffer in the back part
  localparam int OUT_DEPTH = 4;
  localparam int OAW       = $clog2(OUT_DEPTH);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  // register indexes
  localparam logic [2:0] CFG_ROT_COS   = 3'd0;
  localparam logic [2:0] CFG_ROT_SIN   = 3'd1;
  localparam logic [2:0] CFG_SPR_W     = 3'd2;
  localparam logic [2:0] CFG_SPR_H     = 3'd3;
  localparam logic [2:0] CFG_FRAME_ROW = 3'd4;
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd5;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd6;
  localparam logic [2:0] CFG_BLEND     = 3'd7;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // blend modes, the two remaining codes copy
  localparam logic [1:0] MODE_BLEND = 2'd0;
  localparam logic [1:0] MODE_CLAMP = 2'd1;

  typedef struct packed {
    logic [15:0] rot_cos;
    logic [15:0] rot_sin;
    logic [8:0]  sprite_width;
    logic [8:0]  sprite_height;
    logic [11:0] frame_row_offset;
    logic [10:0] origin_x;
    logic [10:0] origin_y;
    logic [26:0] blend_control;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rot_cos:          16'd16384,
    rot_sin:          16'd0,
    sprite_width:     9'd1,
    sprite_height:    9'd1,
    frame_row_offset: 12'd0,
    origin_x:         11'd0,
    origin_y:         11'd0,
    blend_control:    27'd0
  };

  // one queued word: a store write or a classified draw
  typedef struct packed {
    logic              is_draw;
    logic              ok;
    logic [SPR_AW-1:0] addr;
    logic [31:0]       rgba;
    logic [9:0]        dst_x;
    logic [9:0]        dst_y;
    logic [7:0]        dest_r;
    logic [7:0]        dest_g;
    logic [7:0]        dest_b;
  } entry_t;

  typedef struct packed {
    logic       write_valid;
    logic [9:0] dst_x;
    logic [9:0] dst_y;
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;
  } res_t;

endpackage

// ----- rtl/core/rsab_ram.sv -----
// generic single-port ram with registered read data
// no dependencies
module rsab_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rsab_front.sv -----
// front part: accepts words, rotates draw positions, checks bounds, forms store address
// depends on rsab_pkg
module rsab_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rsab_pkg::cfg_t          cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [11:0]             texel_index_i,
  input  logic [31:0]             texel_rgba_i,
  input  logic [7:0]              src_x_i,
  input  logic [7:0]              src_y_i,
  input  logic [7:0]              dest_r_i,
  input  logic [7:0]              dest_g_i,
  input  logic [7:0]              dest_b_i,
  input  logic [rsab_pkg::QCW-1:0] q_cnt_i,
  output logic                    push_o,
  output rsab_pkg::entry_t        push_data_o
);
  import rsab_pkg::*;

  logic              in_acc;
  logic [7:0]        cx, cy;
  logic signed [9:0] dx, dy;
  logic [11:0]       sx, sy;
  logic              scr_ok, load_ok;
  logic [QCW+1:0]    credit;

  logic              v1_q, v2_q, v3_q;
  entry_t            e1_d, e1_q, e2_d, e2_q, e3_d, e3_q;
  logic signed [25:0] p_xc_d, p_ys_d, p_xs_d, p_yc_d;
  logic signed [25:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;

  logic [26:0]       vx, vy, vx_r, vy_r;
  logic [13:0]       px, py;
  logic              inb;
  logic [8:0]        px2_q;
  logic [12:0]       row2_d, row2_q;
  logic [21:0]       mul3;
  logic [22:0]       addr3;

  // every accepted word is guaranteed a queue slot, so the stages never stall
  assign credit     = (QCW + 2)'(q_cnt_i) + (QCW + 2)'(v1_q) + (QCW + 2)'(v2_q)
                    + (QCW + 2)'(v3_q);
  assign in_ready_o = credit < (QCW + 2)'(QDEPTH);
  assign in_acc     = in_valid_i && in_ready_o;

  // stage 1: offsets from the sprite centre, the four products, screen and load bounds
  assign cx = cfg_i.sprite_width[8:1];
  assign cy = cfg_i.sprite_height[8:1];
  assign dx = $signed({2'b00, src_x_i}) - $signed({2'b00, cx});
  assign dy = $signed({2'b00, src_y_i}) - $signed({2'b00, cy});
  assign p_xc_d = 26'(dx) * 26'($signed(cfg_i.rot_cos));
  assign p_ys_d = 26'(dy) * 26'($signed(cfg_i.rot_sin));
  assign p_xs_d = 26'(dx) * 26'($signed(cfg_i.rot_sin));
  assign p_yc_d = 26'(dy) * 26'($signed(cfg_i.rot_cos));

  assign sx = {4'b0000, src_x_i} + {cfg_i.origin_x[10], cfg_i.origin_x};
  assign sy = {4'b0000, src_y_i} + {cfg_i.origin_y[10], cfg_i.origin_y};
  assign scr_ok = !sx[11] && (sx[10:0] < 11'(SCREEN_W))
               && !sy[11] && (sy[10:0] < 11'(SCREEN_H));
  assign load_ok = {1'b0, texel_index_i} < 13'(SPRITE_WORDS);

  always_comb begin
    e1_d         = '0;
    e1_d.is_draw = (req_type_i == REQ_DRAW);
    e1_d.ok      = (req_type_i == REQ_DRAW) ? scr_ok : load_ok;
    e1_d.addr    = texel_index_i[SPR_AW-1:0];
    e1_d.rgba    = texel_rgba_i;
    e1_d.dst_x   = sx[9:0];
    e1_d.dst_y   = sy[9:0];
    e1_d.dest_r  = dest_r_i;
    e1_d.dest_g  = dest_g_i;
    e1_d.dest_b  = dest_b_i;
  end

  // stage 2: sum, round to nearest with ties up, recentre, sprite bounds
  assign vx   = {p_xc_q[25], p_xc_q} - {p_ys_q[25], p_ys_q};
  assign vy   = {p_xs_q[25], p_xs_q} + {p_yc_q[25], p_yc_q};
  assign vx_r = vx + 27'd8192;
  assign vy_r = vy + 27'd8192;
  assign px   = {vx_r[26], vx_r[26:14]} + {6'b000000, cx};
  assign py   = {vy_r[26], vy_r[26:14]} + {6'b000000, cy};
  assign inb  = !px[13] && (px[12:0] < {4'b0000, cfg_i.sprite_width})
             && !py[13] && (py[12:0] < {4'b0000, cfg_i.sprite_height});
  assign row2_d = {4'b0000, py[8:0]} + {1'b0, cfg_i.frame_row_offset};

  always_comb begin
    e2_d = e1_q;
    if (e1_q.is_draw) begin
      e2_d.ok = e1_q.ok && inb;
    end
  end

  // stage 3: store address of the rotated texel
  assign mul3  = 22'(row2_q) * 22'(cfg_i.sprite_width);
  assign addr3 = {1'b0, mul3} + {14'd0, px2_q};

  always_comb begin
    e3_d = e2_q;
    if (e2_q.is_draw) begin
      e3_d.ok   = e2_q.ok && (addr3 < 23'(SPRITE_WORDS));
      e3_d.addr = addr3[SPR_AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q   <= e1_d;
    p_xc_q <= p_xc_d;
    p_ys_q <= p_ys_d;
    p_xs_q <= p_xs_d;
    p_yc_q <= p_yc_d;
    e2_q   <= e2_d;
    px2_q  <= px[8:0];
    row2_q <= row2_d;
    e3_q   <= e3_d;
  end

  assign push_o      = v3_q;
  assign push_data_o = e3_q;

endmodule

// ----- rtl/core/rsab_queue.sv -----
// short queue of classified words between the front and back parts
// depends on rsab_pkg
module rsab_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  rsab_pkg::entry_t         push_data_i,
  input  logic                     pop_i,
  output logic                     head_valid_o,
  output rsab_pkg::entry_t         head_o,
  output logic [rsab_pkg::QCW-1:0] cnt_o
);
  import rsab_pkg::*;

  entry_t         buf_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QCW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + QAW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= push_data_i;
    end
  end

  assign head_valid_o = (cnt_q != '0);
  assign head_o       = buf_q[rptr_q];
  assign cnt_o        = cnt_q;

endmodule

// ----- rtl/core/rsab_back.sv -----
// back part: sprite store access, tint and alpha blend, result buffer
// depends on rsab_pkg and rsab_ram
module rsab_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsab_pkg::cfg_t   cfg_i,
  input  logic             head_valid_i,
  input  rsab_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsab_pkg::res_t   out_o
);
  import rsab_pkg::*;

  // x / 255 for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] t;
    t = x + 17'd1 + {8'd0, x[16:8]};
    return t[15:8];
  endfunction

  logic           room;
  logic           ram_we;
  logic [31:0]    tex;
  logic [7:0]     alpha;
  logic           tint;
  logic [7:0]     src_r, src_g, src_b;

  logic           vb1_q, vb2_q;
  entry_t         b1_q;
  logic           wr2_q, copy2_q;
  logic [9:0]     dx2_q, dy2_q;
  logic [7:0]     sr2_q, sg2_q, sb2_q;
  logic [15:0]    pdr_q, pdg_q, pdb_q, psr_q, psg_q, psb_q;

  res_t           res3;
  res_t           obuf_q [OUT_DEPTH];
  logic [OAW-1:0] owptr_q, orptr_q;
  logic [OCW-1:0] ocnt_q, ocnt_d;
  logic           opop;

  // a draw is popped only when the result buffer has a slot for it
  assign room  = ((OCW + 1)'(ocnt_q) + (OCW + 1)'(vb1_q) + (OCW + 1)'(vb2_q))
               < (OCW + 1)'(OUT_DEPTH);
  assign pop_o = head_valid_i && (!head_i.is_draw || room);
  assign ram_we = pop_o && !head_i.is_draw && head_i.ok;

  rsab_ram #(
    .Width (32),
    .Depth (SPRITE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (head_i.addr),
    .wdata_i (head_i.rgba),
    .rdata_o (tex)
  );

  // texel word is here in the cycle after the pop
  assign alpha = tex[31:24];
  assign tint  = cfg_i.blend_control[2];
  assign src_r = tint ? cfg_i.blend_control[10:3]  : tex[7:0];
  assign src_g = tint ? cfg_i.blend_control[18:11] : tex[15:8];
  assign src_b = tint ? cfg_i.blend_control[26:19] : tex[23:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q <= 1'b0;
      vb2_q <= 1'b0;
    end else begin
      vb1_q <= pop_o && head_i.is_draw;
      vb2_q <= vb1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q    <= head_i;
    wr2_q   <= b1_q.ok && (alpha != 8'd0);
    copy2_q <= !(cfg_i.blend_control[1:0] == MODE_BLEND
              || cfg_i.blend_control[1:0] == MODE_CLAMP);
    dx2_q   <= b1_q.dst_x;
    dy2_q   <= b1_q.dst_y;
    sr2_q   <= src_r;
    sg2_q   <= src_g;
    sb2_q   <= src_b;
    pdr_q   <= 16'(b1_q.dest_r) * 16'(8'd255 - alpha);
    pdg_q   <= 16'(b1_q.dest_g) * 16'(8'd255 - alpha);
    pdb_q   <= 16'(b1_q.dest_b) * 16'(8'd255 - alpha);
    psr_q   <= 16'(src_r) * 16'(alpha);
    psg_q   <= 16'(src_g) * 16'(alpha);
    psb_q   <= 16'(src_b) * 16'(alpha);
  end

  always_comb begin
    res3 = '0;
    if (wr2_q) begin
      res3.write_valid = 1'b1;
      res3.dst_x       = dx2_q;
      res3.dst_y       = dy2_q;
      res3.out_r       = copy2_q ? sr2_q : div255({1'b0, pdr_q} + {1'b0, psr_q});
      res3.out_g       = copy2_q ? sg2_q : div255({1'b0, pdg_q} + {1'b0, psg_q});
      res3.out_b       = copy2_q ? sb2_q : div255({1'b0, pdb_q} + {1'b0, psb_q});
    end
  end

  // result buffer
  assign out_valid_o = (ocnt_q != '0);
  assign opop        = out_valid_o && out_ready_i;
  assign out_o       = obuf_q[orptr_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (vb2_q && !opop) begin
      ocnt_d = ocnt_q + OCW'(1);
    end else if (opop && !vb2_q) begin
      ocnt_d = ocnt_q - OCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      ocnt_q <= ocnt_d;
      if (vb2_q) begin
        owptr_q <= (owptr_q == OAW'(OUT_DEPTH - 1)) ? '0 : owptr_q + OAW'(1);
      end
      if (opop) begin
        orptr_q <= (orptr_q == OAW'(OUT_DEPTH - 1)) ? '0 : orptr_q + OAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vb2_q) begin
      obuf_q[owptr_q] <= res3;
    end
  end

endmodule

// ----- rtl/core/rotated_sprite_alpha_blit.sv -----
// rotated sprite blitter with alpha blend, top level
// a draw passes front stages, queue, back stages, result buffer; low out_ready_i holds it
// throughput: one word per cycle unless stalled, load or draw; one store port, once per word
// reset: registers return to their reset values, queue and result buffer empty;
// the sprite store is not cleared and must be loaded before it is drawn from
module rotated_sprite_alpha_blit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [26:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [11:0] texel_index_i,
  input  logic [31:0] texel_rgba_i,
  input  logic [7:0]  src_x_i,
  input  logic [7:0]  src_y_i,
  input  logic [7:0]  dest_r_i,
  input  logic [7:0]  dest_g_i,
  input  logic [7:0]  dest_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_valid_o,
  output logic [9:0]  dst_x_o,
  output logic [9:0]  dst_y_o,
  output logic [7:0]  out_r_o,
  output logic [7:0]  out_g_o,
  output logic [7:0]  out_b_o
);
  import rsab_pkg::*;

  cfg_t           cfg_q, cfg_d;
  logic           push, pop, head_valid;
  entry_t         push_data, head;
  logic [QCW-1:0] q_cnt;
  res_t           res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROT_COS:   cfg_d.rot_cos          = cfg_data_i[15:0];
        CFG_ROT_SIN:   cfg_d.rot_sin          = cfg_data_i[15:0];
        CFG_SPR_W:     cfg_d.sprite_width     = cfg_data_i[8:0];
        CFG_SPR_H:     cfg_d.sprite_height    = cfg_data_i[8:0];
        CFG_FRAME_ROW: cfg_d.frame_row_offset = cfg_data_i[11:0];
        CFG_ORIGIN_X:  cfg_d.origin_x         = cfg_data_i[10:0];
        CFG_ORIGIN_Y:  cfg_d.origin_y         = cfg_data_i[10:0];
        CFG_BLEND:     cfg_d.blend_control    = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rsab_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .texel_index_i (texel_index_i),
    .texel_rgba_i  (texel_rgba_i),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .dest_r_i      (dest_r_i),
    .dest_g_i      (dest_g_i),
    .dest_b_i      (dest_b_i),
    .q_cnt_i       (q_cnt),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rsab_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .cnt_o        (q_cnt)
  );

  rsab_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign write_valid_o = res.write_valid;
  assign dst_x_o       = res.dst_x;
  assign dst_y_o       = res.dst_y;
  assign out_r_o       = res.out_r;
  assign out_g_o       = res.out_g;
  assign out_b_o       = res.out_b;

endmodule
